>>> design/esps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esps_pkg: shared types and constants
// Beat formats, opcodes, register indexes, reset values and the sequencer
// state type of the step pattern sequencer.
// ----------------------------------------------------------------------------
package esps_pkg;

  // Opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ENC  = 2'd1;
  localparam logic [1:0] OP_SCAN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TEMPO_LOW  = 2'd0;
  localparam logic [1:0] REG_TEMPO_HIGH = 2'd1;
  localparam logic [1:0] REG_DIVIDEND   = 2'd2;

  // Field widths
  localparam int TEMPO_W  = 9;
  localparam int PERIOD_W = 16;
  localparam int DIVD_W   = 20;
  localparam int CFG_W    = 20;

  // Reset values
  localparam logic [TEMPO_W-1:0]  TEMPO_LOW_RST  = 9'd30;
  localparam logic [TEMPO_W-1:0]  TEMPO_HIGH_RST = 9'd300;
  localparam logic [DIVD_W-1:0]   DIVIDEND_RST   = 20'd468750;
  localparam logic [TEMPO_W-1:0]  TEMPO_RST      = 9'd120;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd3906;

  // Quadrature phases
  localparam logic [1:0] PH_00 = 2'd0;
  localparam logic [1:0] PH_01 = 2'd1;
  localparam logic [1:0] PH_10 = 2'd2;
  localparam logic [1:0] PH_11 = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic       enc_a;
    logic       enc_b;
    logic [7:0] buttons_raw;
  } req_t;

  typedef struct packed {
    logic [7:0]          led_byte;
    logic                gate;
    logic [2:0]          step_index;
    logic [TEMPO_W-1:0]  tempo_now;
    logic [PERIOD_W-1:0] step_period;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } seq_state_t;

endpackage

>>> design/eight_step_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_step_pattern_sequencer: step pattern sequencer top level
// Step timer, quadrature tempo encoder, button toggles and LED readout, with
// a serial divider that works out the step period after each tempo change.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_valid/req_stall take one item per beat (timer tick, encoder pin
//   change or button scan); rsp/rsp_valid/rsp_stall give back exactly one
//   result beat per request beat, in order. cfg_we/cfg_index/cfg_data write
//   tempo_low, tempo_high and period_dividend; the user must do so only while the
//   block is idle, which it does not enforce. A new dividend is picked up at the next tempo change.
// Timing:
//   Ticks, scans, opcode 3 and encoder moves outside the 00<->01 pair: result
//   registered at the accepting edge, 1 beat per cycle while the output is not stalled.
//   Encoder moves 00->01 and 01->00 run the 20-bit serial divider, one
//   quotient bit per cycle, even with the tempo pinned at a limit; req_stall
//   stays high through ST_DIV and ST_LOAD, and the result is registered from
//   ST_LOAD once the output register is free, with the new step period.
// Back-pressure and reset:
//   A result held under rsp_stall keeps its payload; a new request is taken
//   only when the output register is free or being drained. rst
//   (synchronous) returns all registers to their reset values, bar the result
//   payload and the divider datapath, which have none, and drops rsp_valid.
// ----------------------------------------------------------------------------
module eight_step_pattern_sequencer #(
  parameter int STEPS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  esps_pkg::req_t               req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output esps_pkg::rsp_t               rsp,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [esps_pkg::CFG_W-1:0]   cfg_data
);
  import esps_pkg::*;

  localparam int SW = $clog2(STEPS);

  // configuration
  logic [TEMPO_W-1:0]  tempo_low;
  logic [TEMPO_W-1:0]  tempo_high;
  logic [DIVD_W-1:0]   period_dividend;

  // sequencer state
  seq_state_t          state, state_next;
  logic [1:0]          phase, phase_next;
  logic [TEMPO_W-1:0]  tempo, tempo_next;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] tick_count, tick_count_next;
  logic [SW-1:0]       step, step_next;
  logic [7:0]          pattern, pattern_next;
  logic [7:0]          prev_pressed, prev_pressed_next;

  logic                accept;
  logic                out_free;
  logic                recalc;
  logic                div_start;
  logic                div_done;
  logic                load_now;
  logic [PERIOD_W-1:0] div_q;
  logic [PERIOD_W:0]   tick_inc;
  logic [4:0]          step_ext;
  logic [4:0]          step_next_ext;
  logic [7:0]          mark;
  logic [7:0]          pressed;
  logic [7:0]          scan_led;
  logic                scan_gate;
  logic                is_scan;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign is_scan  = req.opcode == OP_SCAN;

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_low       <= TEMPO_LOW_RST;
      tempo_high      <= TEMPO_HIGH_RST;
      period_dividend <= DIVIDEND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMPO_LOW:  tempo_low       <= cfg_data[TEMPO_W-1:0];
        REG_TEMPO_HIGH: tempo_high      <= cfg_data[TEMPO_W-1:0];
        REG_DIVIDEND:   period_dividend <= cfg_data[DIVD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- step timer: advance on a zero count, wrap once the next count passes
  // the period (compared one bit wider so a full period still wraps)
  assign tick_inc = {1'b0, tick_count} + (PERIOD_W+1)'(1);
  assign step_ext = 5'(step);

  always_comb begin
    step_next       = step;
    tick_count_next = tick_count;
    if (req.opcode == OP_TICK) begin
      if (tick_count == '0) begin
        step_next = (step == SW'(STEPS - 1)) ? '0 : step + SW'(1);
      end
      tick_count_next = (tick_inc > {1'b0, period}) ? '0 : tick_inc[PERIOD_W-1:0];
    end
  end

  assign step_next_ext = 5'(step_next);

  // ---- quadrature decoder: only the 00->01 and 01->00 moves touch tempo
  always_comb begin
    phase_next = phase;
    tempo_next = tempo;
    recalc     = 1'b0;
    if (req.opcode == OP_ENC) begin
      case (phase)
        PH_00: begin
          if (req.enc_a) begin
            phase_next = PH_10;
          end else if (req.enc_b) begin
            phase_next = PH_01;
            recalc     = 1'b1;
            if (tempo < tempo_high) tempo_next = tempo + TEMPO_W'(1);
          end
        end
        PH_01: begin
          if (req.enc_a) begin
            phase_next = PH_11;
          end else if (!req.enc_b) begin
            phase_next = PH_00;
            recalc     = 1'b1;
            if (tempo > tempo_low) tempo_next = tempo - TEMPO_W'(1);
          end
        end
        PH_10: begin
          if (!req.enc_a) phase_next = PH_00;
          else if (req.enc_b) phase_next = PH_11;
        end
        default: begin
          if (!req.enc_a) phase_next = PH_01;
          else if (!req.enc_b) phase_next = PH_10;
        end
      endcase
    end
  end

  // ---- button scan: toggle pattern bits on new presses
  assign mark      = (step_ext < 5'd8) ? (8'd1 << step_ext[2:0]) : 8'd0;
  assign pressed   = ~req.buttons_raw;
  assign scan_led  = pattern ^ mark;
  assign scan_gate = |(pattern & mark);

  always_comb begin
    pattern_next      = pattern;
    prev_pressed_next = prev_pressed;
    if (is_scan) begin
      pattern_next      = pattern ^ (pressed & ~prev_pressed);
      prev_pressed_next = pressed;
    end
  end

  // ---- period divider
  esps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (period_dividend),
    .divisor  (tempo_next),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && recalc) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_LOAD;
      ST_LOAD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != ST_IDLE) || !out_free;
    div_start = accept && recalc;
    load_now  = (accept && !recalc) || (state == ST_LOAD && out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_00;
      tempo        <= TEMPO_RST;
      period       <= PERIOD_RST;
      tick_count   <= '0;
      step         <= '0;
      pattern      <= '0;
      prev_pressed <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        phase        <= phase_next;
        tempo        <= tempo_next;
        tick_count   <= tick_count_next;
        step         <= step_next;
        pattern      <= pattern_next;
        prev_pressed <= prev_pressed_next;
      end
      if (div_done) period <= div_q;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_now) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      if (accept) begin
        rsp.led_byte    <= is_scan ? scan_led : 8'd0;
        rsp.gate        <= is_scan && scan_gate;
        rsp.step_index  <= step_next_ext[2:0];
        rsp.tempo_now   <= tempo_next;
        rsp.step_period <= period;
      end else begin
        rsp.led_byte    <= 8'd0;
        rsp.gate        <= 1'b0;
        rsp.step_index  <= step_ext[2:0];
        rsp.tempo_now   <= tempo;
        rsp.step_period <= period;
      end
    end
  end

  // ---- checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside of a divide");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    5'(step) <= 5'(STEPS - 1))
    else $error("step beyond the last step");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_LOAD || (accept && !recalc)))
    else $error("result raised without an item behind it");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !accept && !div_start)
    else $error("item taken while the divider runs");

endmodule

>>> design/esps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esps_div: serial period divider
// Restoring divider, one quotient bit per cycle; quotient saturates at the
// period width. A zero divisor yields an all-ones quotient, hence saturation.
// ----------------------------------------------------------------------------
module esps_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [esps_pkg::DIVD_W-1:0]    dividend,
  input  logic [esps_pkg::TEMPO_W-1:0]   divisor,
  output logic                           done,
  output logic [esps_pkg::PERIOD_W-1:0]  quotient
);
  import esps_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVD_W-1:0]    num;
  logic [DIVD_W-1:0]    quo;
  logic [TEMPO_W-1:0]   rem;
  logic [TEMPO_W-1:0]   dsr;
  logic [TEMPO_W:0]     trial;
  logic                 fits;

  assign trial = {rem, num[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      num <= {num[DIVD_W-2:0], 1'b0};
      quo <= {quo[DIVD_W-2:0], fits};
      rem <= fits ? TEMPO_W'(trial - {1'b0, dsr}) : trial[TEMPO_W-1:0];
    end
  end

  // saturate when any bit above the period width is set
  assign quotient = (|quo[DIVD_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}} : quo[PERIOD_W-1:0];

endmodule
